FILE: design/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg - text console glyph renderer package
// Shared widths, constants, register indexes, and the sequencer and action types.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   // widths of the item fields
   localparam int FONT_ADDR_W = 12;
   localparam int CODE_W      = 8;
   localparam int PIXEL_W     = 24;
   localparam int BITS_W      = 8;

   // cursor and internal widths
   localparam int COLUMN_W    = 12;
   localparam int ROWPIX_W    = 16;
   localparam int ROWCNT_W    = 6;
   localparam int GLYPH_W     = 7;
   localparam int GADDR_W     = 15;   // glyph_offset + glyph*bytes_per_glyph + row
   localparam int MUL_A_W     = 16;
   localparam int MUL_B_W     = 13;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam logic [CODE_W-1:0]   CODE_NUL       = 8'd0;
   localparam logic [CODE_W-1:0]   CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0]   CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0]   CODE_ASCII_END = 8'd128;
   localparam logic [ROWCNT_W-1:0] MAX_ROWS       = 6'd32;
   localparam logic [3:0]          MAX_WIDTH      = 4'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GLYPH_WIDTH     = 3'd0,
      REG_GLYPH_HEIGHT    = 3'd1,
      REG_BYTES_PER_GLYPH = 3'd2,
      REG_NUM_GLYPHS      = 3'd3,
      REG_GLYPH_OFFSET    = 3'd4,
      REG_SCREEN_WIDTH    = 3'd5,
      REG_SCANLINE        = 3'd6,
      REG_LINE_ADVANCE    = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GLYPH,
      ST_MUL_COL,
      ST_MUL_ROW,
      ST_SUM,
      ST_ROWS
   } state_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_CHAR = 1'b1
   } action_type;

endpackage

FILE: design/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/text_console_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core - bitmap font text console renderer
// Holds a font store and a text cursor; turns character codes into glyph
// rows addressed as framebuffer pixel indices.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | valid / stall    | action, font_address, font_byte, char_code
//  rsp     | out | valid / stall    | pixel_index, row_bits, last_row
//  csr     | in  | valid / ready    | index (3 bits), data (14 bits)
//
//  Font loads, newline, backspace and code 0 leave the sequencer idle.
//  A rendered glyph keeps req_stall high through three passes of the shared
//  multiplier plus a sum, then one font read per row through the single RAM
//  read port, then the drain of the fetch stage into the output register.
//  rsp_stall freezes the row fetch; req is freed once the fetch stage drains.
//  Reset (synchronous) clears the cursor and all valid flags and sets the CSRs to
//  defaults; the font store is not cleared and must be loaded before use.
//
module text_console_glyph_renderer_core #(
   parameter int FONT_BYTES = 4096   // power of two, 256 to 65536
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [tcgr_pkg::FONT_ADDR_W-1:0]   req_font_address,
   input  logic [7:0]                         req_font_byte,
   input  logic [tcgr_pkg::CODE_W-1:0]        req_char_code,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tcgr_pkg::PIXEL_W-1:0]       rsp_pixel_index,
   output logic [tcgr_pkg::BITS_W-1:0]        rsp_row_bits,
   output logic                               rsp_last_row,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tcgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = $clog2(FONT_BYTES);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [3:0]  glyph_width_ff;
   logic [5:0]  glyph_height_ff;
   logic [5:0]  bytes_per_glyph_ff;
   logic [8:0]  num_glyphs_ff;
   logic [11:0] glyph_offset_ff;
   logic [12:0] screen_width_ff;
   logic [13:0] scanline_ff;
   logic [6:0]  line_advance_ff;

   // ------------------------------------------------------------------
   // sequencer and datapath registers
   // ------------------------------------------------------------------
   tcgr_pkg::state_type state_ff, state_in;

   logic [tcgr_pkg::COLUMN_W-1:0] cursor_column_ff, cursor_column_in;
   logic [tcgr_pkg::ROWPIX_W-1:0] cursor_row_ff, cursor_row_in;

   logic [tcgr_pkg::GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [tcgr_pkg::MUL_P_W-1:0]  prod_ff, prod_in;
   logic [tcgr_pkg::GADDR_W-1:0]  gaddr_ff, gaddr_in;
   logic [tcgr_pkg::PIXEL_W-1:0]  base_ff, base_in;
   logic [tcgr_pkg::PIXEL_W-1:0]  pix_ff, pix_in;
   logic [tcgr_pkg::ROWCNT_W-1:0] issue_y_ff, issue_y_in;

   // fetch stage: one row in flight in the RAM read register
   logic                          f_vld_ff, f_vld_in;
   logic [tcgr_pkg::PIXEL_W-1:0]  f_pix_ff, f_pix_in;
   logic                          f_last_ff, f_last_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcgr_pkg::PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic [tcgr_pkg::BITS_W-1:0]   rsp_bits_ff, rsp_bits_in;
   logic                          rsp_last_ff, rsp_last_in;

   // shared multiplier operands
   logic [tcgr_pkg::MUL_A_W-1:0]  mul_a;
   logic [tcgr_pkg::MUL_B_W-1:0]  mul_b;

   // effective glyph geometry
   logic [3:0]                    w_eff;
   logic [tcgr_pkg::ROWCNT_W-1:0] h_eff;
   logic [tcgr_pkg::BITS_W-1:0]   row_mask;

   // handshakes and strobes
   logic req_accept;
   logic out_free;
   logic issue;
   logic done;

   // font store ports
   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [tcgr_pkg::GADDR_W-1:0]  rd_addr_full;
   logic [7:0]                    ram_rd_data;

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (FONT_BYTES)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_font_byte),
      .rd_en   (issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // glue
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != tcgr_pkg::ST_IDLE);
   assign req_accept = req_valid && (state_ff == tcgr_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign ram_wr_en   = req_accept && (req_action == tcgr_pkg::ACT_LOAD);
   assign ram_wr_addr = ADDR_W'(req_font_address);   // wraps at the store size

   assign rd_addr_full = gaddr_ff + tcgr_pkg::GADDR_W'(issue_y_ff);
   assign ram_rd_addr  = ADDR_W'(rd_addr_full);

   // width is clamped to 1..8, height to at most 32
   always_comb begin
      if (glyph_width_ff == 4'd0) begin
         w_eff = 4'd1;
      end else if (glyph_width_ff > tcgr_pkg::MAX_WIDTH) begin
         w_eff = tcgr_pkg::MAX_WIDTH;
      end else begin
         w_eff = glyph_width_ff;
      end
      if (glyph_height_ff > tcgr_pkg::MAX_ROWS) begin
         h_eff = tcgr_pkg::MAX_ROWS;
      end else begin
         h_eff = glyph_height_ff;
      end
   end

   assign row_mask = 8'hFF >> (tcgr_pkg::MAX_WIDTH - w_eff);

   // row fetch: issue while rows remain and the fetch slot can move on
   assign issue = (state_ff == tcgr_pkg::ST_ROWS) && (issue_y_ff != h_eff)
                  && (!f_vld_ff || out_free);
   assign done  = (state_ff == tcgr_pkg::ST_ROWS) && (issue_y_ff == h_eff)
                  && (!f_vld_ff || out_free);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         tcgr_pkg::ST_MUL_GLYPH: begin
            mul_a = tcgr_pkg::MUL_A_W'(glyph_ff);
            mul_b = tcgr_pkg::MUL_B_W'(bytes_per_glyph_ff);
         end
         tcgr_pkg::ST_MUL_COL: begin
            mul_a = tcgr_pkg::MUL_A_W'(cursor_column_ff);
            mul_b = tcgr_pkg::MUL_B_W'(w_eff) + tcgr_pkg::MUL_B_W'(1);
         end
         tcgr_pkg::ST_MUL_ROW: begin
            mul_a = cursor_row_ff;
            mul_b = screen_width_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // next state and datapath
   // ------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      glyph_in         = glyph_ff;
      prod_in          = tcgr_pkg::MUL_P_W'(mul_a) * tcgr_pkg::MUL_P_W'(mul_b);
      gaddr_in         = gaddr_ff;
      base_in          = base_ff;
      pix_in           = pix_ff;
      issue_y_in       = issue_y_ff;

      case (state_ff)
         tcgr_pkg::ST_IDLE: begin
            if (req_accept && (req_action == tcgr_pkg::ACT_CHAR)) begin
               case (req_char_code)
                  tcgr_pkg::CODE_NUL: begin
                     // ignored
                  end
                  tcgr_pkg::CODE_NEWLINE: begin
                     cursor_row_in    = cursor_row_ff
                                        + tcgr_pkg::ROWPIX_W'(line_advance_ff);
                     cursor_column_in = '0;
                  end
                  tcgr_pkg::CODE_BACKSPACE: begin
                     if (cursor_column_ff != '0) begin
                        cursor_column_in = cursor_column_ff - 1'b1;
                     end
                  end
                  default: begin
                     // out-of-range codes fall back to glyph zero
                     if ((req_char_code < tcgr_pkg::CODE_ASCII_END)
                         && (9'(req_char_code) < num_glyphs_ff)) begin
                        glyph_in = tcgr_pkg::GLYPH_W'(req_char_code);
                     end else begin
                        glyph_in = '0;
                     end
                     state_in = tcgr_pkg::ST_MUL_GLYPH;
                  end
               endcase
            end
         end
         tcgr_pkg::ST_MUL_GLYPH: begin
            state_in = tcgr_pkg::ST_MUL_COL;
         end
         tcgr_pkg::ST_MUL_COL: begin
            gaddr_in = tcgr_pkg::GADDR_W'(glyph_offset_ff)
                       + tcgr_pkg::GADDR_W'(prod_ff);
            state_in = tcgr_pkg::ST_MUL_ROW;
         end
         tcgr_pkg::ST_MUL_ROW: begin
            base_in  = tcgr_pkg::PIXEL_W'(prod_ff);
            state_in = tcgr_pkg::ST_SUM;
         end
         tcgr_pkg::ST_SUM: begin
            pix_in     = base_ff + tcgr_pkg::PIXEL_W'(prod_ff);
            issue_y_in = '0;
            state_in   = tcgr_pkg::ST_ROWS;
         end
         tcgr_pkg::ST_ROWS: begin
            if (issue) begin
               pix_in     = pix_ff + tcgr_pkg::PIXEL_W'(scanline_ff);
               issue_y_in = issue_y_ff + 1'b1;
            end
            if (done) begin
               cursor_column_in = cursor_column_ff + 1'b1;
               state_in         = tcgr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcgr_pkg::ST_IDLE;
         end
      endcase
   end

   // fetch stage and output register
   always_comb begin
      f_vld_in     = f_vld_ff;
      f_pix_in     = f_pix_ff;
      f_last_in    = f_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;

      if (out_free) begin
         rsp_valid_in = f_vld_ff;
         if (f_vld_ff) begin
            rsp_pixel_in = f_pix_ff;
            rsp_bits_in  = ram_rd_data & row_mask;
            rsp_last_in  = f_last_ff;
         end
      end

      if (issue) begin
         f_vld_in  = 1'b1;
         f_pix_in  = pix_ff;
         f_last_in = ((issue_y_ff + 1'b1) == h_eff);
      end else if (f_vld_ff && out_free) begin
         f_vld_in  = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= tcgr_pkg::ST_IDLE;
         cursor_column_ff   <= '0;
         cursor_row_ff      <= '0;
         issue_y_ff         <= '0;
         f_vld_ff           <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         glyph_width_ff     <= 4'd8;
         glyph_height_ff    <= 6'd16;
         bytes_per_glyph_ff <= 6'd16;
         num_glyphs_ff      <= 9'd256;
         glyph_offset_ff    <= 12'd32;
         screen_width_ff    <= 13'd1024;
         scanline_ff        <= 14'd1024;
         line_advance_ff    <= 7'd16;
      end else begin
         state_ff         <= state_in;
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
         issue_y_ff       <= issue_y_in;
         f_vld_ff         <= f_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (tcgr_pkg::csr_index_type'(csr_index))
               tcgr_pkg::REG_GLYPH_WIDTH:     glyph_width_ff     <= csr_data[3:0];
               tcgr_pkg::REG_GLYPH_HEIGHT:    glyph_height_ff    <= csr_data[5:0];
               tcgr_pkg::REG_BYTES_PER_GLYPH: bytes_per_glyph_ff <= csr_data[5:0];
               tcgr_pkg::REG_NUM_GLYPHS:      num_glyphs_ff      <= csr_data[8:0];
               tcgr_pkg::REG_GLYPH_OFFSET:    glyph_offset_ff    <= csr_data[11:0];
               tcgr_pkg::REG_SCREEN_WIDTH:    screen_width_ff    <= csr_data[12:0];
               tcgr_pkg::REG_SCANLINE:        scanline_ff        <= csr_data[13:0];
               tcgr_pkg::REG_LINE_ADVANCE:    line_advance_ff    <= csr_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      prod_ff      <= prod_in;
      gaddr_ff     <= gaddr_in;
      base_ff      <= base_in;
      pix_ff       <= pix_in;
      f_pix_ff     <= f_pix_in;
      f_last_ff    <= f_last_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_pixel_ff;
   assign rsp_row_bits    = rsp_bits_ff;
   assign rsp_last_row    = rsp_last_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_fetch_only_in_rows: assert property (@(posedge clock) disable iff (reset)
      f_vld_ff |-> (state_ff == tcgr_pkg::ST_ROWS))
      else $error("fetch stage busy outside row phase");

   a_row_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcgr_pkg::ST_ROWS) |-> (issue_y_ff <= h_eff))
      else $error("row counter ran past glyph height");

   a_font_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == tcgr_pkg::ST_IDLE))
      else $error("font store written while rendering");

   a_column_advance: assert property (@(posedge clock) disable iff (reset)
      done |=> (cursor_column_ff == $past(cursor_column_ff) + 1'b1))
      else $error("column did not advance after glyph");

   a_no_issue_when_held: assert property (@(posedge clock) disable iff (reset)
      (f_vld_ff && rsp_valid_ff && rsp_stall) |-> !issue)
      else $error("row fetched over a held one");

endmodule
